// File: hw/rtl/uest_pkg.sv
// Shared opcodes, status codes and controller/datapath interface types for the set table.
package uest_pkg;

    // Field widths of the item ports.
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int ELEM_W   = 32;

    // Operation codes carried in the opcode field.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the item and its match vector
        logic update;   // apply the operation and load the result register
    } uest_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } uest_sts_t;

endpackage

// File: hw/rtl/uest_ctrl.sv
// Controller state machine that sequences the compare and update steps of one item.
module uest_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  uest_pkg::uest_sts_t sts,
    output uest_pkg::uest_cmd_t cmd
);
    import uest_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic state_reg;
    logic state_next;

    // An item is taken only while idle; the match vector is captured with it.
    assign in_stall   = (state_reg != ST_IDLE);
    assign cmd.load   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.update = (state_reg == ST_UPDATE) && sts.out_free;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/uest_dpath.sv
// Datapath holding the entry array, the count, the parallel compare and the result register.
module uest_dpath
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  uest_pkg::uest_cmd_t              cmd,
    output uest_pkg::uest_sts_t              sts,
    input  logic [uest_pkg::OP_W-1:0]        opcode,
    input  logic [uest_pkg::ELEM_W-1:0]      element,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [uest_pkg::STATUS_W-1:0]    status,
    output logic                             found,
    output logic [uest_pkg::COUNT_W-1:0]     count
);
    import uest_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    // Stored values and fill level.
    logic [VALUE_WIDTH-1:0] entries_reg  [CAPACITY];
    logic [VALUE_WIDTH-1:0] entries_next [CAPACITY];
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    // Captured item and its match vector.
    logic [OP_W-1:0]        op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [CAPACITY-1:0]    hit_reg;
    logic [CAPACITY-1:0]    hit_next;
    logic [VALUE_WIDTH-1:0] elem_val;

    // Result register.
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [STATUS_W-1:0]    status_next;
    logic                   found_reg;
    logic                   found_next;
    logic [COUNT_W-1:0]     count_out_reg;

    // Update decode.
    logic                   any_hit;
    logic                   do_insert;
    logic                   do_erase;
    logic [IW-1:0]          ins_idx;
    logic [CAPACITY-1:0]    shift_en;

    // Only the low VALUE_WIDTH bits of the element take part.
    assign elem_val = VALUE_WIDTH'(element);

    // Compare the item against every occupied slot in parallel.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cmp
        assign hit_next[g] = (CW'(g) < count_reg) && (entries_reg[g] == elem_val);
        // Slots at and above the erased one take the next slot's value.
        assign shift_en[g] = |hit_reg[g:0];
    end

    assign any_hit   = |hit_reg;
    assign ins_idx   = count_reg[IW-1:0];
    assign do_insert = cmd.update && (op_reg == OP_INSERT) && !any_hit
                       && (count_reg != CW'(CAPACITY));
    assign do_erase  = cmd.update && (op_reg == OP_ERASE) && any_hit;

    // Status, found flag and new count of the operation.
    always_comb
    begin
        status_next = ST_OK;
        found_next  = 1'b0;
        count_next  = count_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (any_hit)
                begin
                    status_next = ST_DUP;
                    found_next  = 1'b1;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_ERASE:
            begin
                if (any_hit)
                begin
                    found_next = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            OP_LOOKUP:
            begin
                found_next = any_hit;
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Next value of each slot: append at the fill level, or close the gap on erase.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_ent
        if (g < CAPACITY - 1)
        begin : g_mid
            always_comb
            begin
                entries_next[g] = entries_reg[g];
                if (do_insert && (ins_idx == IW'(g)))
                begin
                    entries_next[g] = val_reg;
                end
                else if (do_erase && shift_en[g])
                begin
                    entries_next[g] = entries_reg[g + 1];
                end
            end
        end
        else
        begin : g_last
            always_comb
            begin
                entries_next[g] = entries_reg[g];
                if (do_insert && (ins_idx == IW'(g)))
                begin
                    entries_next[g] = val_reg;
                end
            end
        end
    end

    // Entry storage, no reset: slots at and above the count are never read.
    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            val_reg <= elem_val;
            hit_reg <= hit_next;
        end
    end

    // Fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign count        = count_out_reg;

    // The fill level never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("set table count above capacity");

    // Stored values are distinct, so at most one slot matches.
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $onehot0(hit_reg))
        else $error("set table holds a duplicate value");

    // A clear leaves the table empty.
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && (op_reg == OP_CLEAR)) |=> (count_reg == '0))
        else $error("set table not empty after clear");

endmodule

// File: hw/rtl/unique_element_set_table_core.sv
// An accepted item and its match vector are captured in the item register; the update step then loads
// the result register once it is free, and no new item is accepted until that update is done.
// An item is accepted while a previous result still waits; a stalled result delays the update.
// Reset clears the count, the controller and the result valid; entries need no clearing.
// Top level of the fixed-capacity set table with insertion-order storage.
module unique_element_set_table_core
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [uest_pkg::OP_W-1:0]     opcode,
    input  logic [uest_pkg::ELEM_W-1:0]   element,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [uest_pkg::STATUS_W-1:0] status,
    output logic                          found,
    output logic [uest_pkg::COUNT_W-1:0]  count
);
    import uest_pkg::*;

    uest_cmd_t cmd;
    uest_sts_t sts;

    // Sequencer.
    uest_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Storage, compare and result register.
    uest_dpath
    #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (opcode),
        .element   (element),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found     (found),
        .count     (count)
    );

endmodule
